>>> src/adwa_pkg.sv
// Shared types and constants of the audio DMA write address unit.
package adwa_pkg;

  localparam int ADDR_W   = 20;
  localparam int DATA_W   = 16;
  localparam int OFFSET_W = 32;
  localparam int INDEX_W  = 3;
  localparam int CFG_W    = ADDR_W;
  // Channel offset: 256-halfword stripe index plus position, wraps at 1024.
  localparam int CHAN_W   = 10;
  localparam int OUT_W    = 40;

  typedef enum logic [1:0] {
    MODE_AUTO_WRITE   = 2'd0,
    MODE_AUTO_READ    = 2'd1,
    MODE_MANUAL_WRITE = 2'd2,
    MODE_MANUAL_READ  = 2'd3
  } dma_mode_t;

  typedef enum logic [INDEX_W-1:0] {
    REG_DMA_MODE      = 3'd0,
    REG_AUTO_ENABLE   = 3'd1,
    REG_START_ADDRESS = 3'd2,
    REG_LEFT_BASE     = 3'd3,
    REG_RIGHT_BASE    = 3'd4,
    REG_IRQ_ADDRESS   = 3'd5,
    REG_IRQ_ENABLE    = 3'd6
  } reg_index_t;

  typedef struct packed {
    dma_mode_t         dma_mode;
    logic              auto_enable;
    logic [ADDR_W-1:0] start_address;
    logic [ADDR_W-1:0] left_base;
    logic [ADDR_W-1:0] right_base;
    logic [ADDR_W-1:0] irq_address;
    logic              irq_enable;
  } cfg_t;

  typedef struct packed {
    logic              write_valid;
    logic [ADDR_W-1:0] write_address;
    logic [DATA_W-1:0] write_data;
    logic              need_data;
    logic              auto_end;
    logic              interrupt_request;
  } result_t;

endpackage

>>> src/audio_dma_write_address_unit_core.sv
// Top level of the audio DMA write address unit.
//
//  channel   direction  tdata / data                              tuser
//  s_axis    in         [15:0] fifo_data                          fifo_valid
//  m_axis    out        [19:0] write_address, [35:20] write_data, write_valid
//                       [36] need_data, [37] auto_end,
//                       [38] interrupt_request, [39] zero
//  cfg       in         cfg_write, cfg_index, cfg_data[19:0]      -
//
// One request per cycle while m_axis_tready allows; results pass the input register, then the result register.
// The path between them is the 32-bit offset increment and a 20-bit add and compare.
// Reset clears the configuration, the offset and all flags.
// While a result waits on m_axis_tready, one more request is held in the input register.
module audio_dma_write_address_unit_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [adwa_pkg::DATA_W-1:0]        s_axis_tdata,  // [15:0] fifo_data
  input  logic                               s_axis_tuser,  // [0] fifo_valid
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [19:0] write_address, [35:20] write_data, [36] need_data,
  // [37] auto_end, [38] interrupt_request, [39] zero
  output logic [adwa_pkg::OUT_W-1:0]         m_axis_tdata,
  output logic                               m_axis_tuser,  // [0] write_valid
  input  logic                               cfg_write,
  input  logic [adwa_pkg::INDEX_W-1:0]       cfg_index,
  input  logic [adwa_pkg::CFG_W-1:0]         cfg_data
);

  adwa_pkg::cfg_t    cfg;
  adwa_pkg::result_t result;
  adwa_pkg::result_t out_reg;

  logic                        in_valid;
  logic                        in_fifo_valid;
  logic [adwa_pkg::DATA_W-1:0] in_fifo_data;
  logic                        advance;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  adwa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  adwa_step u_step (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .advance    (advance),
    .fifo_valid (in_fifo_valid),
    .fifo_data  (in_fifo_data),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_fifo_valid <= s_axis_tuser;
      in_fifo_data  <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_reg <= result;
  end

  assign m_axis_tuser = out_reg.write_valid;
  assign m_axis_tdata = {1'b0, out_reg.interrupt_request, out_reg.auto_end,
                         out_reg.need_data, out_reg.write_data, out_reg.write_address};

endmodule

>>> src/adwa_cfg.sv
// Configuration register file of the audio DMA write address unit.
module adwa_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [adwa_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [adwa_pkg::CFG_W-1:0]    cfg_data,
  output adwa_pkg::cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (adwa_pkg::reg_index_t'(cfg_index))
        adwa_pkg::REG_DMA_MODE:      cfg.dma_mode      <= adwa_pkg::dma_mode_t'(cfg_data[1:0]);
        adwa_pkg::REG_AUTO_ENABLE:   cfg.auto_enable   <= cfg_data[0];
        adwa_pkg::REG_START_ADDRESS: cfg.start_address <= cfg_data[adwa_pkg::ADDR_W-1:0];
        adwa_pkg::REG_LEFT_BASE:     cfg.left_base     <= cfg_data[adwa_pkg::ADDR_W-1:0];
        adwa_pkg::REG_RIGHT_BASE:    cfg.right_base    <= cfg_data[adwa_pkg::ADDR_W-1:0];
        adwa_pkg::REG_IRQ_ADDRESS:   cfg.irq_address   <= cfg_data[adwa_pkg::ADDR_W-1:0];
        adwa_pkg::REG_IRQ_ENABLE:    cfg.irq_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

>>> src/adwa_step.sv
// Per-tick address generation, offset counter and status flags.
module adwa_step (
  input  logic                         clk,
  input  logic                         rst,
  input  adwa_pkg::cfg_t               cfg,
  input  logic                         advance,
  input  logic                         fifo_valid,
  input  logic [adwa_pkg::DATA_W-1:0]  fifo_data,
  output adwa_pkg::result_t            result
);

  logic [adwa_pkg::OFFSET_W-1:0] transfer_offset, transfer_offset_next;
  logic                          irq_flag, irq_flag_next;
  logic                          need_data_flag, need_data_flag_next;
  logic                          auto_end_flag, auto_end_flag_next;

  logic                          is_auto;
  logic                          is_manual;
  logic                          wrote;
  logic [adwa_pkg::CHAN_W-1:0]   chan;
  logic [adwa_pkg::ADDR_W-1:0]   base;
  logic [adwa_pkg::ADDR_W-1:0]   auto_addr;
  logic [adwa_pkg::ADDR_W-1:0]   manual_addr;
  logic [adwa_pkg::ADDR_W-1:0]   addr;

  assign is_auto   = (cfg.dma_mode == adwa_pkg::MODE_AUTO_WRITE) && cfg.auto_enable;
  assign is_manual = (cfg.dma_mode == adwa_pkg::MODE_MANUAL_WRITE);
  assign wrote     = (is_auto || is_manual) && fifo_valid;

  // Stripes of 256 left then 256 right; offset bit 8 picks the channel.
  assign chan      = {transfer_offset[10:9], transfer_offset[7:0]};
  assign base      = transfer_offset[8] ? cfg.right_base : cfg.left_base;
  assign auto_addr = base + {{(adwa_pkg::ADDR_W-adwa_pkg::CHAN_W){1'b0}}, chan};
  assign manual_addr = cfg.start_address + transfer_offset[adwa_pkg::ADDR_W-1:0];
  assign addr      = is_auto ? auto_addr : manual_addr;

  always_comb begin
    transfer_offset_next = transfer_offset;
    irq_flag_next        = irq_flag;
    need_data_flag_next  = need_data_flag;
    auto_end_flag_next   = auto_end_flag;
    if (is_auto || is_manual) begin
      if (!fifo_valid) begin
        need_data_flag_next = 1'b1;
        if (is_auto) auto_end_flag_next = 1'b1;
      end else begin
        need_data_flag_next = 1'b0;
        if (is_auto) auto_end_flag_next = 1'b0;
        if (addr == cfg.irq_address) irq_flag_next = 1'b1;
        transfer_offset_next = transfer_offset + adwa_pkg::OFFSET_W'(1);
      end
    end
  end

  always_comb begin
    result.write_valid       = wrote;
    result.write_address     = wrote ? addr : '0;
    result.write_data        = wrote ? fifo_data : '0;
    result.need_data         = need_data_flag_next;
    result.auto_end          = auto_end_flag_next;
    result.interrupt_request = cfg.irq_enable & irq_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      transfer_offset <= '0;
      irq_flag        <= 1'b0;
      need_data_flag  <= 1'b0;
      auto_end_flag   <= 1'b0;
    end else if (advance) begin
      transfer_offset <= transfer_offset_next;
      irq_flag        <= irq_flag_next;
      need_data_flag  <= need_data_flag_next;
      auto_end_flag   <= auto_end_flag_next;
    end
  end

endmodule

>>> src/adwa_checker.sv
// Port-level assertions for the audio DMA write address unit, with bind.
module adwa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [adwa_pkg::OUT_W-1:0]    m_axis_tdata,
  input logic                          m_axis_tuser
);

  // Nothing comes out in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // The input side only stalls behind a stalled result.
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // A tick without a write carries zero address and data.
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[35:0] == 36'd0))
    else $error("non-write result carries address or data");

  // A write always clears the need-data status.
  a_write_clears_need: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> !m_axis_tdata[36])
    else $error("need_data set on a write");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind audio_dma_write_address_unit_core adwa_checker u_adwa_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> tb/sv/tb.sv
// Self-checking testbench for audio_dma_write_address_unit_core.
module tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 950;

  // Predicts the write path and compares each result against the oldest expectation.
  class write_address_scoreboard;
    adwa_pkg::cfg_t                cfg;
    logic [adwa_pkg::OFFSET_W-1:0] offset;
    bit                            irq_flag;
    bit                            need_flag;
    bit                            end_flag;
    adwa_pkg::result_t             expected_writes[$];
    int                            errors;
    int                            requests;
    int                            auto_writes;
    int                            manual_writes;
    int                            empty_ticks;
    int                            irq_hits;

    function new();
      cfg = '0;
      offset = '0;
      irq_flag = 0;
      need_flag = 0;
      end_flag = 0;
    endfunction

    function void set_reg(adwa_pkg::reg_index_t idx, logic [adwa_pkg::CFG_W-1:0] value);
      case (idx)
        adwa_pkg::REG_DMA_MODE:      cfg.dma_mode = adwa_pkg::dma_mode_t'(value[1:0]);
        adwa_pkg::REG_AUTO_ENABLE:   cfg.auto_enable = value[0];
        adwa_pkg::REG_START_ADDRESS: cfg.start_address = value[adwa_pkg::ADDR_W-1:0];
        adwa_pkg::REG_LEFT_BASE:     cfg.left_base = value[adwa_pkg::ADDR_W-1:0];
        adwa_pkg::REG_RIGHT_BASE:    cfg.right_base = value[adwa_pkg::ADDR_W-1:0];
        adwa_pkg::REG_IRQ_ADDRESS:   cfg.irq_address = value[adwa_pkg::ADDR_W-1:0];
        adwa_pkg::REG_IRQ_ENABLE:    cfg.irq_enable = value[0];
        default: ;
      endcase
    endfunction

    // Manual: start + offset. Auto: 256-halfword stripes alternate left/right,
    // channel offset wraps at 1024.
    function logic [adwa_pkg::ADDR_W-1:0] target_address(
        adwa_pkg::cfg_t c, logic [adwa_pkg::OFFSET_W-1:0] off);
      logic [adwa_pkg::CHAN_W-1:0] chan;
      logic [adwa_pkg::ADDR_W-1:0] base;
      if (c.dma_mode == adwa_pkg::MODE_MANUAL_WRITE)
        return c.start_address + off[adwa_pkg::ADDR_W-1:0];
      chan = {off[10:9], off[7:0]};
      base = off[8] ? c.right_base : c.left_base;
      return base + adwa_pkg::ADDR_W'(chan);
    endfunction

    function void take_request(bit fifo_valid, logic [adwa_pkg::DATA_W-1:0] fifo_data);
      adwa_pkg::result_t           r;
      bit                          auto_wr;
      bit                          manual_wr;
      logic [adwa_pkg::ADDR_W-1:0] addr;
      r = '0;
      auto_wr = (cfg.dma_mode == adwa_pkg::MODE_AUTO_WRITE) && cfg.auto_enable;
      manual_wr = (cfg.dma_mode == adwa_pkg::MODE_MANUAL_WRITE);
      if (auto_wr || manual_wr) begin
        if (!fifo_valid) begin
          need_flag = 1;
          if (auto_wr) end_flag = 1;
          empty_ticks++;
        end else begin
          need_flag = 0;
          if (auto_wr) end_flag = 0;
          addr = target_address(cfg, offset);
          if (addr == cfg.irq_address) begin
            irq_flag = 1;
            irq_hits++;
          end
          offset = offset + 1;
          r.write_valid = 1;
          r.write_address = addr;
          r.write_data = fifo_data;
          if (auto_wr) auto_writes++;
          else manual_writes++;
        end
      end
      r.need_data = need_flag;
      r.auto_end = end_flag;
      r.interrupt_request = cfg.irq_enable & irq_flag;
      expected_writes.push_back(r);
      requests++;
    endfunction

    function void compare_field(string name, longint exp_val, longint act_val);
      if (exp_val != act_val) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(bit write_valid, logic [adwa_pkg::OUT_W-1:0] data);
      adwa_pkg::result_t e;
      if (expected_writes.size() == 0) begin
        $error("result with no request outstanding: tuser %0b tdata 0x%0h", write_valid, data);
        errors++;
        return;
      end
      e = expected_writes.pop_front();
      compare_field("write_valid", e.write_valid, write_valid);
      compare_field("write_address", e.write_address, data[19:0]);
      compare_field("write_data", e.write_data, data[35:20]);
      compare_field("need_data", e.need_data, data[36]);
      compare_field("auto_end", e.auto_end, data[37]);
      compare_field("interrupt_request", e.interrupt_request, data[38]);
      compare_field("tdata pad bit", 0, data[39]);
    endfunction

    function int pending();
      return expected_writes.size();
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [adwa_pkg::DATA_W-1:0]   s_axis_tdata;
  logic                          s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [adwa_pkg::OUT_W-1:0]    m_axis_tdata;
  logic                          m_axis_tuser;
  logic                          cfg_write;
  logic [adwa_pkg::INDEX_W-1:0]  cfg_index;
  logic [adwa_pkg::CFG_W-1:0]    cfg_data;

  write_address_scoreboard sb = new();
  adwa_pkg::cfg_t cur_cfg;
  int   cycles = 0;
  int   setups;

  audio_dma_write_address_unit_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("audio_dma_write_address_unit_core verification failed");
      $finish;
    end
  end

  // Input noted before the output check; results trail requests through the input and result registers.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.take_request(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tuser, m_axis_tdata);
    end
  end

  // Receiver backpressure: short stalls, short ready runs, occasional long ready runs.
  initial begin
    int run;
    bit level;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      case ($urandom_range(0, 7))
        0: begin level = 1'b1; run = $urandom_range(20, 80); end
        1, 2: begin level = 1'b0; run = $urandom_range(1, 6); end
        default: begin level = 1'b1; run = $urandom_range(1, 8); end
      endcase
      m_axis_tready <= level;
      repeat (run) @(posedge clk);
    end
  end

  task automatic write_reg(adwa_pkg::reg_index_t idx, logic [adwa_pkg::CFG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  task automatic program_all(adwa_pkg::cfg_t c);
    write_reg(adwa_pkg::REG_DMA_MODE, adwa_pkg::CFG_W'(c.dma_mode));
    write_reg(adwa_pkg::REG_AUTO_ENABLE, adwa_pkg::CFG_W'(c.auto_enable));
    write_reg(adwa_pkg::REG_START_ADDRESS, c.start_address);
    write_reg(adwa_pkg::REG_LEFT_BASE, c.left_base);
    write_reg(adwa_pkg::REG_RIGHT_BASE, c.right_base);
    write_reg(adwa_pkg::REG_IRQ_ADDRESS, c.irq_address);
    write_reg(adwa_pkg::REG_IRQ_ENABLE, adwa_pkg::CFG_W'(c.irq_enable));
    cfg_write <= 1'b0;
    setups++;
  endtask

  task automatic push_request(bit fifo_valid, logic [adwa_pkg::DATA_W-1:0] fifo_data);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fifo_valid;
    s_axis_tdata  <= fifo_data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Block must be idle before the configuration changes.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Bursts of random length with random gaps; empty_pct sets the empty-FIFO rate.
  task automatic send_stream(int count, int empty_pct, int gap_pct);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < count; i++) begin
        push_request($urandom_range(0, 99) >= empty_pct, adwa_pkg::DATA_W'($urandom));
        sent++;
      end
      if (sent < count && $urandom_range(0, 99) < gap_pct) begin
        gap = $urandom_range(1, 6);
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [adwa_pkg::ADDR_W-1:0] pick_addr();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return adwa_pkg::ADDR_W'($urandom_range(0, 20'hFFFFF));
    endcase
  endfunction

  initial begin
    int total;
    int n;
    int r;
    adwa_pkg::cfg_t c;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_write     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    cur_cfg = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Out of reset: auto mode without enable does nothing.
    push_request(1'b1, 16'hFFFF);
    push_request(1'b0, 16'h0000);
    wait_idle();

    // Auto write: left base at the top wraps to zero, interrupt on the wrapped address.
    cur_cfg.dma_mode = adwa_pkg::MODE_AUTO_WRITE;
    cur_cfg.auto_enable = 1'b1;
    cur_cfg.start_address = '0;
    cur_cfg.left_base = 20'hFFFFF;
    cur_cfg.right_base = 20'h00000;
    cur_cfg.irq_address = 20'h00000;
    cur_cfg.irq_enable = 1'b1;
    program_all(cur_cfg);
    push_request(1'b1, 16'h0000);
    push_request(1'b1, 16'hFFFF);
    push_request(1'b0, 16'hFFFF);
    push_request(1'b1, 16'hA5A5);
    push_request(1'b0, 16'h0000);
    push_request(1'b0, 16'hFFFF);
    push_request(1'b1, 16'h5A5A);
    push_request(1'b0, 16'h1234);
    wait_idle();

    // Manual write: start address wraps, auto_end left over from auto mode stays set,
    // sticky flag hidden by irq_enable low.
    cur_cfg.dma_mode = adwa_pkg::MODE_MANUAL_WRITE;
    cur_cfg.start_address = 20'hFFFFF;
    cur_cfg.irq_address = 20'h00004;
    cur_cfg.irq_enable = 1'b0;
    program_all(cur_cfg);
    push_request(1'b1, 16'hFFFF);
    push_request(1'b1, 16'h0001);
    push_request(1'b0, 16'h0000);
    wait_idle();

    // Read modes are idle; the sticky flag shows again once enabled.
    cur_cfg.dma_mode = adwa_pkg::MODE_AUTO_READ;
    cur_cfg.irq_enable = 1'b1;
    program_all(cur_cfg);
    push_request(1'b1, 16'hBEEF);
    push_request(1'b0, 16'h0000);
    wait_idle();
    cur_cfg.dma_mode = adwa_pkg::MODE_MANUAL_READ;
    program_all(cur_cfg);
    push_request(1'b1, 16'hFFFF);
    push_request(1'b0, 16'h0000);
    wait_idle();

    // Auto write with auto DMA disabled is idle too.
    cur_cfg.dma_mode = adwa_pkg::MODE_AUTO_WRITE;
    cur_cfg.auto_enable = 1'b0;
    program_all(cur_cfg);
    push_request(1'b1, 16'hFFFF);
    push_request(1'b0, 16'h0000);
    wait_idle();

    // Random phases, weighted toward the write modes.
    total = 0;
    while (total < RANDOM_ITEMS) begin
      r = $urandom_range(0, 19);
      if (r < 9) c.dma_mode = adwa_pkg::MODE_AUTO_WRITE;
      else if (r < 16) c.dma_mode = adwa_pkg::MODE_MANUAL_WRITE;
      else if (r < 18) c.dma_mode = adwa_pkg::MODE_AUTO_READ;
      else c.dma_mode = adwa_pkg::MODE_MANUAL_READ;
      c.auto_enable = ($urandom_range(0, 9) != 0);
      c.start_address = pick_addr();
      c.left_base = pick_addr();
      c.right_base = pick_addr();
      c.irq_enable = ($urandom_range(0, 3) != 0);
      // Half the time aim the interrupt address at an upcoming write.
      if ($urandom_range(0, 1) == 1)
        c.irq_address = sb.target_address(c, sb.offset + $urandom_range(0, 40));
      else
        c.irq_address = pick_addr();
      program_all(c);
      n = $urandom_range(80, 160);
      if (n > RANDOM_ITEMS - total) n = RANDOM_ITEMS - total;
      case ($urandom_range(0, 3))
        0: r = 40;
        1: r = 12;
        default: r = 3;
      endcase
      send_stream(n, r, ($urandom_range(0, 3) == 0) ? 0 : 35);
      total += n;
      wait_idle();
    end

    $display("Covered %0d requests: %0d auto writes, %0d manual writes, %0d empty-FIFO ticks.",
             sb.requests, sb.auto_writes, sb.manual_writes, sb.empty_ticks);
    $display("%0d register setups, %0d interrupt address matches, final offset %0d.",
             setups, sb.irq_hits, sb.offset);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("audio_dma_write_address_unit_core verification clean");
    else
      $display("audio_dma_write_address_unit_core verification failed");
    $finish;
  end

endmodule
